>>> hdl/hmmff_pkg.sv
// package for the seven-state hmm forward filter
// constants, coefficient tables and shared types; no dependencies
`timescale 1ns / 1ps
package hmmff_pkg;

    localparam int FRAC_BITS = 15;
    localparam int NST       = 7;
    localparam int BW        = FRAC_BITS + 1;      // belief width
    localparam int CW        = FRAC_BITS + 1;      // coefficient width
    localparam int HW        = 24;                 // history width
    localparam int AW        = BW + CW + 3;        // accumulator width
    localparam int SW        = HW + 3;             // normalization sum width
    localparam int NW        = SW + FRAC_BITS;     // dividend / numerator width
    localparam logic [BW-1:0] ONE_Q = BW'(1) << FRAC_BITS;
    localparam logic [HW-1:0] HIST_MAX = {HW{1'b1}};

    localparam logic [1:0] OBS_NORMAL = 2'd2;
    localparam logic [1:0] MODE_HIST  = 2'd1;
    localparam logic [1:0] MODE_AVG   = 2'd2;
    localparam logic [2:0] ST_QUIET   = 3'd1;

    typedef logic [BW-1:0] belief_t;

    // quantize thousandths, rounded to nearest
    function automatic logic [CW-1:0] to_q(input int m);
        longint v;
        begin
            v = ((longint'(m) << FRAC_BITS) + 500) / 1000;
            return CW'(v);
        end
    endfunction

    function automatic logic [CW-1:0] trans_q(input logic [2:0] j, input logic [2:0] k);
        int t [0:6][0:6];
        begin
            t = '{'{421, 362, 61, 60, 27, 34, 32},
                  '{213, 509, 90, 55, 39, 51, 42},
                  '{84, 269, 320, 58, 108, 64, 68},
                  '{190, 264, 91, 243, 86, 76, 48},
                  '{56, 262, 123, 75, 293, 69, 121},
                  '{50, 244, 137, 101, 96, 279, 92},
                  '{47, 252, 92, 56, 164, 75, 313}};
            return (j < 3'd7 && k < 3'd7) ? to_q(t[j][k]) : '0;
        end
    endfunction

    function automatic logic [CW-1:0] emit_q(input logic [2:0] k, input logic [1:0] o);
        int e [0:6][0:2];
        begin
            e = '{'{905, 71, 24}, '{143, 179, 679}, '{262, 714, 24}, '{613, 213, 175},
                  '{600, 288, 113}, '{425, 475, 100}, '{388, 513, 100}};
            return (k < 3'd7 && o < 2'd3) ? to_q(e[k][o]) : '0;
        end
    endfunction

    // alphabetical visit order: angry, disgust, fear, happy, quiet, sad, surprise
    function automatic logic [2:0] alpha_idx(input logic [2:0] i);
        case (i)
            3'd0: return 3'd4;
            3'd1: return 3'd6;
            3'd2: return 3'd5;
            3'd3: return 3'd0;
            3'd4: return 3'd1;
            3'd5: return 3'd2;
            3'd6: return 3'd3;
            default: return 3'd1;
        endcase
    endfunction

    typedef struct packed {
        logic          start;
        logic [NW-1:0] num;
        logic [SW-1:0] den;
    } div_req_t;

endpackage

>>> hdl/hmmff_div.sv
// restoring bit-serial divider, one quotient bit per cycle
// depends on hmmff_pkg
`timescale 1ns / 1ps
module hmmff_div
    import hmmff_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  div_req_t      req,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   q_reg, q_next;
    logic [SW:0]     r_reg, r_next;
    logic [SW-1:0]   d_reg, d_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SW+1:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[NW-1]} - {2'b00, d_reg};
        if (req.start)
        begin
            q_next = req.num;
            r_next = '0;
            d_next = req.den;
            cnt_next = CNTW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[SW+1])
            begin
                r_next = trial[SW:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[SW-1:0], q_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo = q_reg;
endmodule

>>> hdl/hmm_forward_filter_seven_state_unit.sv
// seven-state hmm forward filter, top level; depends on hmmff_pkg and hmmff_div
// work per item: one normalization in modes 0 and 3, two in modes 1 and 2; driven by one
// multiply-accumulate step per cycle and by a pass of the shared bit-serial divider
// for each of the 7 entries of every normalization
// throughput: one item in flight, next accept in the cycle after the commit step;
// a waiting result stalls only the commit; reset: async active low, quiet = 1.0, mode 0
`timescale 1ns / 1ps
module hmm_forward_filter_seven_state_unit
    import hmmff_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  mode,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  observation,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] prob_happy,
    output logic [15:0] prob_quiet,
    output logic [15:0] prob_sad,
    output logic [15:0] prob_surprise,
    output logic [15:0] prob_angry,
    output logic [15:0] prob_fear,
    output logic [15:0] prob_disgust,
    output logic [2:0]  top_emotion
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ARG   = 9'b000000010,  // argmax scan of old belief
        S_MAC   = 9'b000000100,  // transition accumulate over j
        S_EMIT  = 9'b000001000,  // emission multiply
        S_SUM   = 9'b000010000,  // sum entries for normalization
        S_DIV   = 9'b000100000,  // divide one entry
        S_ADD   = 9'b001000000,  // add history or old belief
        S_TOP   = 9'b010000000,  // argmax scan of new belief
        S_OUT   = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [1:0]    mode_reg;
    belief_t       bel_reg [NST];
    logic [NW-1:0] q_reg [NST];    // working vector, wide for mode 1 adds
    logic [HW-1:0] hist_reg;
    logic [1:0]    obs_reg;
    logic [2:0]    j_reg, k_reg, i_reg;
    logic [AW-1:0] acc_reg;
    logic [SW-1:0] sum_reg;
    logic [BW-1:0] top_val_reg;
    logic [2:0]    top_idx_reg;
    logic [2:0]    src_reg;        // argmax of old belief
    logic          pass2_reg;      // second normalization pending
    logic          div_wait_reg;
    logic          out_valid_reg;
    logic [2:0]    top_out_reg;

    div_req_t      dreq;
    logic          div_done;
    logic [NW-1:0] div_quo;

    hmmff_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .done (div_done),
        .quo  (div_quo)
    );

    wire single = (mode_reg == MODE_HIST) || (mode_reg == MODE_AVG);
    wire [2:0] scan_idx = alpha_idx(i_reg);
    // the new belief becomes the result once the previous one has left
    wire commit = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // shared multiplier operands
    logic [AW-1:0]     mul_a;
    logic [CW-1:0]     mul_b;
    logic [AW+CW-1:0]  mul_p;
    always_comb
    begin
        if (state_reg == S_EMIT)
        begin
            mul_a = acc_reg >> FRAC_BITS;
            mul_b = emit_q(k_reg, obs_reg);
        end
        else
        begin
            mul_a = AW'(bel_reg[j_reg]);
            mul_b = trans_q(j_reg, k_reg);
        end
        mul_p = mul_a * mul_b;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign dreq.start = (state_reg == S_DIV) && !div_wait_reg;
    assign dreq.num   = q_reg[k_reg] << FRAC_BITS;
    assign dreq.den   = sum_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid && in_ready) state_next = single ? S_ARG : S_MAC;
            S_ARG:   if (i_reg == 3'd6) state_next = S_MAC;
            S_MAC:   if (!single && j_reg != 3'd6) state_next = S_MAC;
                     else state_next = S_EMIT;
            S_EMIT:  state_next = (k_reg == 3'd6) ? S_SUM : S_MAC;
            S_SUM:   if (k_reg == 3'd6) state_next = S_DIV;
            S_DIV:   if (div_done && (k_reg == 3'd6 || sum_reg == '0))
                         state_next = pass2_reg ? S_ADD : S_TOP;
                     else if (sum_reg == '0) state_next = pass2_reg ? S_ADD : S_TOP;
            S_ADD:   if (k_reg == 3'd6) state_next = S_SUM;
            S_TOP:   if (i_reg == 3'd6) state_next = S_OUT;
            S_OUT:   if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg <= '0;
            hist_reg <= '0;
            out_valid_reg <= 1'b0;
            div_wait_reg <= 1'b0;
            for (int n = 0; n < NST; n++)
                bel_reg[n] <= (n == 1) ? ONE_Q : '0;
            i_reg <= '0; j_reg <= '0; k_reg <= '0;
            pass2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                mode_reg <= mode;
            if (commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        obs_reg <= (observation > OBS_NORMAL) ? OBS_NORMAL : observation;
                        i_reg <= '0; j_reg <= '0; k_reg <= '0;
                        acc_reg <= '0;
                        top_val_reg <= '0;
                        top_idx_reg <= ST_QUIET;
                        pass2_reg <= single;
                    end
                end
                S_ARG:
                begin
                    if (bel_reg[scan_idx] > top_val_reg)
                    begin
                        top_val_reg <= bel_reg[scan_idx];
                        top_idx_reg <= scan_idx;
                    end
                    i_reg <= i_reg + 3'd1;
                    if (i_reg == 3'd6)
                    begin
                        j_reg <= (bel_reg[scan_idx] > top_val_reg) ? scan_idx : top_idx_reg;
                        src_reg <= (bel_reg[scan_idx] > top_val_reg) ? scan_idx : top_idx_reg;
                    end
                end
                S_MAC:
                begin
                    acc_reg <= acc_reg + AW'(mul_p);
                    if (!single) j_reg <= j_reg + 3'd1;
                end
                S_EMIT:
                begin
                    q_reg[k_reg] <= NW'(mul_p >> FRAC_BITS);
                    acc_reg <= '0;
                    j_reg <= single ? src_reg : 3'd0;
                    k_reg <= (k_reg == 3'd6) ? 3'd0 : k_reg + 3'd1;
                    sum_reg <= '0;
                end
                S_SUM:
                begin
                    sum_reg <= sum_reg + SW'(q_reg[k_reg]);
                    k_reg <= (k_reg == 3'd6) ? 3'd0 : k_reg + 3'd1;
                    div_wait_reg <= 1'b0;
                end
                S_DIV:
                begin
                    if (sum_reg == '0)
                    begin
                        for (int n = 0; n < NST; n++)
                            q_reg[n] <= (n == 1) ? NW'(ONE_Q) : '0;
                        k_reg <= '0;
                        pass2_reg <= 1'b0;
                        top_val_reg <= '0;
                        top_idx_reg <= ST_QUIET;
                        i_reg <= '0;
                    end
                    else if (!div_wait_reg)
                        div_wait_reg <= 1'b1;
                    else if (div_done)
                    begin
                        q_reg[k_reg] <= div_quo;
                        div_wait_reg <= 1'b0;
                        k_reg <= (k_reg == 3'd6) ? 3'd0 : k_reg + 3'd1;
                        if (k_reg == 3'd6)
                        begin
                            pass2_reg <= 1'b0;
                            top_val_reg <= '0;
                            top_idx_reg <= ST_QUIET;
                            i_reg <= '0;
                        end
                    end
                end
                S_ADD:
                begin
                    q_reg[k_reg] <= q_reg[k_reg] + ((mode_reg == MODE_HIST) ?
                                    NW'(hist_reg) : NW'(bel_reg[k_reg]));
                    k_reg <= (k_reg == 3'd6) ? 3'd0 : k_reg + 3'd1;
                    sum_reg <= '0;
                end
                S_TOP:
                begin
                    if (BW'(q_reg[scan_idx]) > top_val_reg)
                    begin
                        top_val_reg <= BW'(q_reg[scan_idx]);
                        top_idx_reg <= scan_idx;
                    end
                    i_reg <= i_reg + 3'd1;
                end
                S_OUT:
                begin
                    // commit the new belief and update the saturating history
                    if (commit)
                    begin
                        for (int n = 0; n < NST; n++)
                            bel_reg[n] <= BW'(q_reg[n]);
                        if ({1'b0, hist_reg} + (HW + 1)'(top_val_reg) > (HW + 1)'(HIST_MAX))
                            hist_reg <= HIST_MAX;
                        else
                            hist_reg <= hist_reg + HW'(top_val_reg);
                        top_out_reg <= top_idx_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign prob_happy    = 16'(bel_reg[0]);
    assign prob_quiet    = 16'(bel_reg[1]);
    assign prob_sad      = 16'(bel_reg[2]);
    assign prob_surprise = 16'(bel_reg[3]);
    assign prob_angry    = 16'(bel_reg[4]);
    assign prob_fear     = 16'(bel_reg[5]);
    assign prob_disgust  = 16'(bel_reg[6]);
    assign top_emotion   = top_out_reg;

`ifndef SYNTHESIS
    // a waiting result stays valid with its payload unchanged
    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable({prob_happy, prob_quiet,
        prob_sad, prob_surprise, prob_angry, prob_fear, prob_disgust, top_emotion}))
        else $error("pending result changed");
    // one transaction at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction accepted while busy");
    // a result appears only after the commit step
    a_out_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result without commit");
    // history never decreases
    a_hist_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> hist_reg >= $past(hist_reg))
        else $error("history decreased");
`endif
endmodule
